// File: hdl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies; used by every module in hdl/.
package mi3_pkg;

  localparam int CofW   = 65;   // exact 2x2 cofactor, Q33.32 signed
  localparam int DetW   = 100;  // determinant and division working width
  localparam int QW     = 33;   // quotient bits kept before saturation
  localparam int NDiv   = 34;   // overflow check plus one step per quotient bit
  localparam int Lanes  = 9;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] b00;
    logic signed [31:0] b01;
    logic signed [31:0] b02;
    logic signed [31:0] b10;
    logic signed [31:0] b11;
    logic signed [31:0] b12;
    logic signed [31:0] b20;
    logic signed [31:0] b21;
    logic signed [31:0] b22;
    logic               singular;
  } inv_t;

  // word handed from the front pipeline to the divider through the queue
  typedef struct packed {
    logic [Lanes-1:0][CofW-1:0] adj;
    logic [DetW-1:0]            det;
  } qword_t;

  // one stage of the divider pipeline
  typedef struct packed {
    logic                       sing;
    logic [DetW-1:0]            d2;
    logic [Lanes-1:0][DetW-1:0] rem;
    logic [Lanes-1:0][QW-1:0]   q;
    logic [Lanes-1:0]           neg;
    logic [Lanes-1:0]           ovf;
  } bstage_t;

endpackage

// File: hdl/mi3_front.sv
// Front pipeline: input register, cofactors, determinant.
// Depends on mi3_pkg.
module mi3_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            mat_valid,
  output logic            mat_stall,
  input  mi3_pkg::mat_t   mat,
  output logic            f_valid,
  input  logic            f_stall,
  output mi3_pkg::qword_t f_word
);

  localparam int L = mi3_pkg::Lanes;
  localparam int CW = mi3_pkg::CofW;
  localparam int DW = mi3_pkg::DetW;

  logic [5:0] v;
  logic [5:0] adv;

  mi3_pkg::mat_t r0;
  logic signed [17:0][63:0]  prod;
  logic signed [2:0][31:0]   col1, col2;
  logic [L-1:0][CW-1:0]      adj2, adj3, adj4, adj5;
  logic [2:0][CW-1:0]        plo, phi;
  logic [2:0][DW-1:0]        tm;
  logic [DW-1:0]             det;

  logic signed [17:0][63:0]  prod_next;
  logic [L-1:0][CW-1:0]      adj_next;
  logic [2:0][CW-1:0]        plo_next, phi_next;
  logic [2:0][DW-1:0]        tm_next;
  logic [2:0][31:0]          col0;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[5] = !v[5] || !f_stall;
    for (int k = 4; k >= 0; k--) adv[k] = !v[k] || adv[k+1];
  end

  assign mat_stall = !adv[0];
  assign f_valid   = v[5];
  assign f_word    = '{adj: adj5, det: det};

  // first column, element t pairs with adjugate row-0 entry t
  assign col0 = {r0.a20, r0.a10, r0.a00};

  always_comb begin
    prod_next[0]  = r0.a11 * r0.a22;  prod_next[1]  = r0.a12 * r0.a21;
    prod_next[2]  = r0.a02 * r0.a21;  prod_next[3]  = r0.a01 * r0.a22;
    prod_next[4]  = r0.a01 * r0.a12;  prod_next[5]  = r0.a02 * r0.a11;
    prod_next[6]  = r0.a12 * r0.a20;  prod_next[7]  = r0.a10 * r0.a22;
    prod_next[8]  = r0.a00 * r0.a22;  prod_next[9]  = r0.a02 * r0.a20;
    prod_next[10] = r0.a02 * r0.a10;  prod_next[11] = r0.a00 * r0.a12;
    prod_next[12] = r0.a10 * r0.a21;  prod_next[13] = r0.a11 * r0.a20;
    prod_next[14] = r0.a01 * r0.a20;  prod_next[15] = r0.a00 * r0.a21;
    prod_next[16] = r0.a00 * r0.a11;  prod_next[17] = r0.a01 * r0.a10;
  end

  always_comb begin
    for (int k = 0; k < L; k++) begin
      adj_next[k] = {prod[2*k][63], prod[2*k]} - {prod[2*k+1][63], prod[2*k+1]};
    end
  end

  // cofactor times entry, split into two 33x32 partial products
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      plo_next[t] = $signed({1'b0, adj2[t][31:0]}) * $signed(col2[t]);
      phi_next[t] = $signed(adj2[t][CW-1:32]) * $signed(col2[t]);
    end
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      tm_next[t] = ({{(DW-CW){phi[t][CW-1]}}, phi[t]} << 32)
                 + {{(DW-CW){plo[t][CW-1]}}, plo[t]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= mat_valid;
      for (int k = 1; k < 6; k++) if (adv[k]) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) r0 <= mat;
    if (adv[1]) begin
      prod <= prod_next;
      col1 <= col0;
    end
    if (adv[2]) begin
      adj2 <= adj_next;
      col2 <= col1;
    end
    if (adv[3]) begin
      plo  <= plo_next;
      phi  <= phi_next;
      adj3 <= adj2;
    end
    if (adv[4]) begin
      tm   <= tm_next;
      adj4 <= adj3;
    end
    if (adv[5]) begin
      det  <= tm[0] + tm[1] + tm[2];
      adj5 <= adj4;
    end
  end

endmodule

// File: hdl/mi3_queue.sv
// Short queue between the front pipeline and the divider.
// Depends on mi3_pkg.
module mi3_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            f_valid,
  output logic            f_stall,
  input  mi3_pkg::qword_t f_word,
  output logic            q_valid,
  input  logic            q_stall,
  output mi3_pkg::qword_t q_word
);

  mi3_pkg::qword_t mem [mi3_pkg::QDepth];
  logic [mi3_pkg::QPtrW-1:0] wr_ptr, rd_ptr;
  logic [mi3_pkg::QPtrW:0]   cnt;
  logic push, pop;

  assign f_stall = (cnt == (mi3_pkg::QPtrW+1)'(mi3_pkg::QDepth));
  assign q_valid = (cnt != '0);
  assign q_word  = mem[rd_ptr];
  assign push    = f_valid && !f_stall;
  assign pop     = q_valid && !q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + (mi3_pkg::QPtrW+1)'(push) - (mi3_pkg::QPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= f_word;
  end

endmodule

// File: hdl/mi3_back.sv
// Back pipeline: magnitudes, restoring division one bit a stage, rounding,
// saturation and the output register. Depends on mi3_pkg.
module mi3_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_stall,
  input  mi3_pkg::qword_t q_word,
  output logic            inv_valid,
  input  logic            inv_stall,
  output mi3_pkg::inv_t   inv
);

  localparam int L  = mi3_pkg::Lanes;
  localparam int DW = mi3_pkg::DetW;
  localparam int QW = mi3_pkg::QW;
  localparam int ND = mi3_pkg::NDiv;

  mi3_pkg::bstage_t st [ND+1];
  mi3_pkg::bstage_t nx [ND+1];
  logic [ND:0] sv;
  logic [ND:0] adv;
  logic out_adv;
  mi3_pkg::inv_t inv_next;

  // first step checks for overflow, the rest take one quotient bit each
  function automatic mi3_pkg::bstage_t div_step(mi3_pkg::bstage_t x, int sh, logic first);
    mi3_pkg::bstage_t y;
    logic [DW+QW-1:0] sd;
    logic [DW+QW-1:0] rx;
    y  = x;
    sd = {{QW{1'b0}}, x.d2} << sh;
    for (int l = 0; l < L; l++) begin
      rx = {{QW{1'b0}}, x.rem[l]};
      if (first) begin
        y.ovf[l] = (rx >= sd);
      end else if (rx >= sd) begin
        y.rem[l] = x.rem[l] - sd[DW-1:0];
        y.q[l]   = x.q[l] | (QW'(1) << sh);
      end
    end
    return y;
  endfunction

  // entry: sign split and rounding offset, num = 2|adj|*2^32 + |det|
  always_comb begin
    logic [DW-1:0] dmag;
    logic [mi3_pkg::CofW-1:0] amag;
    dmag = q_word.det[DW-1] ? (~q_word.det + 1'b1) : q_word.det;
    nx[0].sing = (q_word.det == '0);
    nx[0].d2   = dmag << 1;
    nx[0].q    = '0;
    nx[0].ovf  = '0;
    for (int l = 0; l < L; l++) begin
      amag = q_word.adj[l][mi3_pkg::CofW-1] ? (~q_word.adj[l] + 1'b1) : q_word.adj[l];
      nx[0].neg[l] = q_word.adj[l][mi3_pkg::CofW-1] ^ q_word.det[DW-1];
      nx[0].rem[l] = ({{(DW-64){1'b0}}, amag[63:0]} << 33) + dmag;
    end
  end

  for (genvar s = 0; s < ND; s++) begin : g_div
    assign nx[s+1] = div_step(st[s], (s == 0) ? QW : QW - s, s == 0);
  end

  always_comb begin
    out_adv = !inv_valid || !inv_stall;
    adv[ND] = !sv[ND] || out_adv;
    for (int k = ND-1; k >= 0; k--) adv[k] = !sv[k] || adv[k+1];
  end
  assign q_stall = !adv[0];

  // saturate to 32 bits and apply sign; zeros when singular
  always_comb begin
    logic [L-1:0][31:0] bv;
    logic [QW-1:0] qn;
    for (int l = 0; l < L; l++) begin
      qn = ~st[ND].q[l] + 1'b1;
      if (st[ND].sing) bv[l] = '0;
      else if (st[ND].neg[l])
        bv[l] = (st[ND].ovf[l] || st[ND].q[l] > QW'(33'h080000000))
              ? 32'h80000000 : qn[31:0];
      else
        bv[l] = (st[ND].ovf[l] || st[ND].q[l] > QW'(33'h07FFFFFFF))
              ? 32'h7FFFFFFF : st[ND].q[l][31:0];
    end
    inv_next = {bv[0], bv[1], bv[2], bv[3], bv[4], bv[5], bv[6], bv[7], bv[8],
                st[ND].sing};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      inv_valid <= 1'b0;
    end else begin
      if (adv[0]) sv[0] <= q_valid;
      for (int k = 1; k <= ND; k++) if (adv[k]) sv[k] <= sv[k-1];
      if (out_adv) inv_valid <= sv[ND];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= ND; k++) if (adv[k]) st[k] <= nx[k];
    if (out_adv) inv <= inv_next;
  end

endmodule

// File: hdl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate method, signed Q16.16 in and out.
// Top level; depends on mi3_pkg, mi3_front, mi3_queue, mi3_back.
//
// One matrix word in, one inverse word out, sustained at one word per clock
// while inv_stall is low. The front pipeline (6 stages: input register, 32x32
// products, cofactors, split 65x32 partial products, term sums, determinant)
// feeds a 4-entry queue; the back pipeline (magnitudes, overflow check, 33
// restoring-division stages, output register) divides all nine adjugate
// entries in parallel lanes, one quotient bit per stage. Results are rounded
// to nearest, ties away from zero, and saturated to 32 bits; an exactly zero
// determinant gives all-zero entries with singular set. Each pipeline stage
// advances whenever it is empty or its successor advances, so bubbles are
// squeezed out and input is taken while a finished result waits at the output.
module matrix_inverse_3x3 (
  input  logic          clk,
  input  logic          rst,
  input  logic          mat_valid,
  output logic          mat_stall,
  input  mi3_pkg::mat_t mat,
  output logic          inv_valid,
  input  logic          inv_stall,
  output mi3_pkg::inv_t inv
);

  logic            f_valid, f_stall;
  mi3_pkg::qword_t f_word;
  logic            q_valid, q_stall;
  mi3_pkg::qword_t q_word;

  // cofactors and determinant
  mi3_front u_front (
    .clk, .rst,
    .mat_valid, .mat_stall, .mat,
    .f_valid, .f_stall, .f_word
  );

  // decouples the two pipelines' stalls
  mi3_queue u_queue (
    .clk, .rst,
    .f_valid, .f_stall, .f_word,
    .q_valid, .q_stall, .q_word
  );

  // division, rounding, saturation
  mi3_back u_back (
    .clk, .rst,
    .q_valid, .q_stall, .q_word,
    .inv_valid, .inv_stall, .inv
  );

endmodule
